// ===== design/selection_sorter_macros.svh =====
// Assertion macros for the selection sorter.
`ifndef SELECTION_SORTER_MACROS_SVH
`define SELECTION_SORTER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define SLS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("selection_sorter: assertion failed");

// Check a property on every clock edge, reset included.
`define SLS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("selection_sorter: assertion failed");

`else

`define SLS_ASSERT(lbl, prop)
`define SLS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== design/sls_pkg.sv =====
// Shared types and constants of the selection sorter.
package sls_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Port field widths
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register word index (paddr[2])
    localparam logic REG_SIGNED = 1'b0;
    localparam logic REG_DESC   = 1'b1;

    // Compare mode handed to the comparator
    typedef struct packed {
        logic is_signed;
        logic descending;
    } t_cmp_mode;

endpackage

// ===== design/sls_cmp.sv =====
// Key comparator: true when key a goes before key b under the compare mode.
module sls_cmp #(
    parameter int KEY_WIDTH = sls_pkg::KEY_WIDTH_DEF
) (
    input  logic [KEY_WIDTH-1:0] i_a,
    input  logic [KEY_WIDTH-1:0] i_b,
    input  sls_pkg::t_cmp_mode   i_mode,
    output logic                 o_before
);

    logic [KEY_WIDTH-1:0] a_adj;
    logic [KEY_WIDTH-1:0] b_adj;

    // Flip the sign bits so that an unsigned compare orders two's complement keys
    always_comb begin
        a_adj = i_a;
        b_adj = i_b;
        if (i_mode.is_signed) begin
            a_adj[KEY_WIDTH-1] = ~i_a[KEY_WIDTH-1];
            b_adj[KEY_WIDTH-1] = ~i_b[KEY_WIDTH-1];
        end
        o_before = i_mode.descending ? (a_adj > b_adj) : (a_adj < b_adj);
    end

endmodule

// ===== design/sls_store.sv =====
// Key memory: one write port, one registered read port.
module sls_store #(
    parameter int MAX_KEYS  = sls_pkg::MAX_KEYS_DEF,
    parameter int KEY_WIDTH = sls_pkg::KEY_WIDTH_DEF,
    localparam int IW       = $clog2(MAX_KEYS)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic [KEY_WIDTH-1:0] i_wr_data,
    input  logic [IW-1:0]        i_rd_addr,
    output logic [KEY_WIDTH-1:0] o_rd_data
);

    logic [KEY_WIDTH-1:0] r_mem [MAX_KEYS];
    logic [KEY_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/selection_sorter.sv =====
// Selection sorter top level: load sequencer, sort sequencer, output register and APB registers.
//
// Keys load at one per cycle, one transaction each, into a single-port-write,
// single-port-read key memory; the transaction that carries last_key closes the
// set and the block then stalls its input until the sorted burst has been
// handed to the output register. For N stored keys the sort runs passes p = 0..N-2,
// each N - p scan reads from position p, then a drain and a swap of the best key
// into place (S_DRAIN, S_SWAP_HI, S_SWAP_LO); every scan step shares the one key
// comparator and the one memory read port. Each burst key is then read (S_EMIT_RD)
// and loaded (S_EMIT_LD), waiting while the consumer stalls, before the next read.
// The input reopens as soon as the final key sits in the output register.
// Keys beyond MAX_KEYS are dropped and flag overflow on every key of the burst.
`include "selection_sorter_macros.svh"

module selection_sorter #(
    parameter int MAX_KEYS  = sls_pkg::MAX_KEYS_DEF,
    parameter int KEY_WIDTH = sls_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // key input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [31:0]                 i_key_value,
    input  logic                        i_last_key,
    // sorted output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_sorted_key,
    output logic                        o_last_out,
    output logic                        o_overflow,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sls_pkg::ADDR_W-1:0]  paddr,
    input  logic [sls_pkg::DATA_W-1:0]  pwdata,
    output logic [sls_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int IW = $clog2(MAX_KEYS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_KEYS);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);
    localparam logic [IW-1:0] ONE_I = IW'(1);

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_SWAP_HI = 3'd3;
    localparam logic [2:0] S_SWAP_LO = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_LD = 3'd6;

    logic [2:0]           r_state,    n_state;
    logic [CW-1:0]        r_count,    n_count;
    logic                 r_dropped,  n_dropped;
    logic [IW-1:0]        r_pos,      n_pos;
    logic [IW-1:0]        r_probe,    n_probe;
    logic                 r_rd_vld,   n_rd_vld;
    logic [IW-1:0]        r_rd_idx,   n_rd_idx;
    logic [IW-1:0]        r_best_idx, n_best_idx;
    logic [KEY_WIDTH-1:0] r_best_val, n_best_val;
    logic [KEY_WIDTH-1:0] r_held,     n_held;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_key,  n_out_key;
    logic                 r_out_last, n_out_last;
    logic                 r_out_ovf,  n_out_ovf;
    logic                 r_signed;
    logic                 r_desc;

    sls_pkg::t_cmp_mode   cmp_mode;
    logic                 cmp_before;
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 in_accept;
    logic                 out_accept;
    logic                 store_room;
    logic                 probe_at_end;
    logic                 cfg_write;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_accept   = r_out_valid && !i_out_stall;
    assign store_room   = (r_count < MAX_C);
    assign probe_at_end = (CW'(r_probe) == CW'(r_count - ONE_C));

    assign cmp_mode.is_signed  = r_signed;
    assign cmp_mode.descending = r_desc;

    sls_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_a      (rd_data),
        .i_b      (r_best_val),
        .i_mode   (cmp_mode),
        .o_before (cmp_before)
    );

    sls_store #(
        .MAX_KEYS  (MAX_KEYS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_probe),
        .o_rd_data (rd_data)
    );

    // Memory write port: load, then the two halves of a swap
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = KEY_WIDTH'(i_key_value);
        unique case (r_state)
            S_LOAD: begin
                wr_en = in_accept && store_room;
            end
            S_SWAP_HI: begin
                wr_en   = 1'b1;
                wr_addr = r_best_idx;
                wr_data = r_held;
            end
            S_SWAP_LO: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_best_val;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_pos       = r_pos;
        n_probe     = r_probe;
        n_rd_vld    = (r_state == S_SCAN);
        n_rd_idx    = r_probe;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_held      = r_held;
        n_out_valid = out_accept ? 1'b0 : r_out_valid;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        // Compare stage: first read of a pass seeds the running best
        if (r_rd_vld) begin
            if (r_rd_idx == r_pos) begin
                n_held     = rd_data;
                n_best_val = rd_data;
                n_best_idx = r_pos;
            end else if (cmp_before) begin
                n_best_val = rd_data;
                n_best_idx = r_rd_idx;
            end
        end

        unique case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    if (store_room) begin
                        n_count = r_count + ONE_C;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last_key) begin
                        n_pos   = '0;
                        n_probe = '0;
                        n_state = (n_count >= TWO_C) ? S_SCAN : S_EMIT_RD;
                    end
                end
            end
            S_SCAN: begin
                if (probe_at_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_probe = r_probe + ONE_I;
                end
            end
            S_DRAIN: begin
                n_state = S_SWAP_HI;
            end
            S_SWAP_HI: begin
                n_state = S_SWAP_LO;
            end
            S_SWAP_LO: begin
                n_pos   = r_pos + ONE_I;
                n_probe = r_pos + ONE_I;
                // another pass while at least two keys remain unplaced
                if ((CW + 1)'(r_pos) + (CW + 1)'(TWO_C) < (CW + 1)'(r_count)) begin
                    n_state = S_SCAN;
                end else begin
                    n_probe = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                // probe doubles as the output index here
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_key   = 32'(rd_data);
                    n_out_last  = probe_at_end;
                    n_out_ovf   = r_dropped;
                    if (probe_at_end) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_probe = r_probe + ONE_I;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_pos       <= '0;
            r_probe     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_pos       <= n_pos;
            r_probe     <= n_probe;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_held     <= n_held;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // Configuration registers
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed <= 1'b0;
            r_desc   <= 1'b0;
        end else if (cfg_write) begin
            if (paddr[2] == sls_pkg::REG_SIGNED) begin
                r_signed <= pwdata[0];
            end
            if (paddr[2] == sls_pkg::REG_DESC) begin
                r_desc <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == sls_pkg::REG_DESC) ? sls_pkg::DATA_W'(r_desc)
                                                    : sls_pkg::DATA_W'(r_signed);
    assign pready = 1'b1;

    assign o_in_stall   = (r_state != S_LOAD);
    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_key;
    assign o_last_out   = r_out_last;
    assign o_overflow   = r_out_ovf;

    `SLS_ASSERT(a_count_bound, (r_count <= MAX_C))
    `SLS_ASSERT(a_last_closes_set, (in_accept && i_last_key) |=> o_in_stall)
    `SLS_ASSERT(a_scan_in_range, (r_state == S_SCAN) |-> (CW'(r_probe) < r_count))
    `SLS_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n) |=> (!o_out_valid && !o_in_stall))

endmodule
